### hw/rtl/matrix3_inverse_assert.svh
// Assertion macros shared by the matrix3_inverse RTL
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define M3I_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define M3I_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/m3i_pkg.sv
// Types and constants for the 3x3 matrix inverse pipeline
package m3i_pkg;

    localparam int LANES      = 9;
    localparam int DIV_STAGES = 32;

    typedef logic signed [15:0] elem_t;
    typedef logic signed [31:0] prod_t;
    typedef logic signed [32:0] adj_t;
    typedef logic signed [48:0] det_t;

    typedef struct packed {
        logic valid;
        logic singular;
    } ctl_t;

    // one division lane: partial remainder, numerator bits still to shift in,
    // quotient bits so far
    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [47:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
    } lane_t;

    // adjugate entry k = m[PA]*m[PB] - m[NA]*m[NB], row-major element order
    localparam int ADJ_PA [LANES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int ADJ_PB [LANES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int ADJ_NA [LANES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int ADJ_NB [LANES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_MIN_MAG = 32'h8000_0000;

endpackage

### hw/rtl/m3i_if.sv
// Valid/ready channel interfaces for matrix words in and inverse words out
interface m3i_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] m00, m01, m02;
    logic signed [15:0] m10, m11, m12;
    logic signed [15:0] m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface m3i_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] r00, r01, r02;
    logic signed [31:0] r10, r11, r12;
    logic signed [31:0] r20, r21, r22;
    logic singular;
    logic saturated;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, saturated, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, saturated, output ready);
endinterface

### hw/rtl/m3i_adj.sv
// Two-stage adjugate: 18 products, then nine differences
module m3i_adj (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  m3i_pkg::ctl_t       ctl_in,
    input  m3i_pkg::elem_t      mat [m3i_pkg::LANES],
    output m3i_pkg::ctl_t       ctl_out,
    output m3i_pkg::adj_t       adj [m3i_pkg::LANES],
    output m3i_pkg::elem_t      row0 [3]
);

    m3i_pkg::ctl_t  ctl_a_reg, ctl_b_reg;
    m3i_pkg::prod_t pos_reg [m3i_pkg::LANES];
    m3i_pkg::prod_t neg_reg [m3i_pkg::LANES];
    m3i_pkg::adj_t  adj_reg [m3i_pkg::LANES];
    m3i_pkg::elem_t row_a_reg [3];
    m3i_pkg::elem_t row_b_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    for (genvar k = 0; k < m3i_pkg::LANES; k++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pos_reg[k] <= mat[m3i_pkg::ADJ_PA[k]] * mat[m3i_pkg::ADJ_PB[k]];
                neg_reg[k] <= mat[m3i_pkg::ADJ_NA[k]] * mat[m3i_pkg::ADJ_NB[k]];
                adj_reg[k] <= 33'(pos_reg[k]) - 33'(neg_reg[k]);
            end
        end
        assign adj[k] = adj_reg[k];
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_row
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                row_a_reg[j] <= mat[j];
                row_b_reg[j] <= row_a_reg[j];
            end
        end
        assign row0[j] = row_b_reg[j];
    end

    assign ctl_out = ctl_b_reg;

endmodule

### hw/rtl/m3i_det.sv
// Determinant by cofactor expansion and divider lane setup, three stages
module m3i_det (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  m3i_pkg::ctl_t       ctl_in,
    input  m3i_pkg::adj_t       adj [m3i_pkg::LANES],
    input  m3i_pkg::elem_t      row0 [3],
    output m3i_pkg::ctl_t       ctl_out,
    output m3i_pkg::lane_t      lane_out [m3i_pkg::LANES],
    output logic [47:0]         dmag
);

    m3i_pkg::ctl_t  ctl_c_reg, ctl_d_reg, ctl_e_reg;
    m3i_pkg::det_t  term_reg [3];
    m3i_pkg::det_t  det_reg;
    m3i_pkg::adj_t  adj_c_reg [m3i_pkg::LANES];
    m3i_pkg::adj_t  adj_d_reg [m3i_pkg::LANES];
    m3i_pkg::lane_t lane_reg [m3i_pkg::LANES];
    logic [47:0]    dmag_reg;

    logic           det_neg;
    m3i_pkg::det_t  det_abs;
    logic [47:0]    dmag_next;

    assign det_neg   = det_reg[48];
    assign det_abs   = det_neg ? -det_reg : det_reg;
    assign dmag_next = det_abs[47:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
            ctl_e_reg <= '0;
        end
        else if (en)
        begin
            ctl_c_reg          <= ctl_in;
            ctl_d_reg          <= ctl_c_reg;
            ctl_e_reg.valid    <= ctl_d_reg.valid;
            ctl_e_reg.singular <= (det_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg[0] <= row0[0] * adj[0];
            term_reg[1] <= row0[1] * adj[3];
            term_reg[2] <= row0[2] * adj[6];
            det_reg     <= term_reg[0] + term_reg[1] + term_reg[2];
            dmag_reg    <= dmag_next;
        end
    end

    for (genvar k = 0; k < m3i_pkg::LANES; k++)
    begin : g_lane
        logic           adj_neg;
        m3i_pkg::adj_t  adj_abs;
        logic [31:0]    amag;
        m3i_pkg::lane_t lane_next;

        assign adj_neg = adj_d_reg[k][32];
        assign adj_abs = adj_neg ? -adj_d_reg[k] : adj_d_reg[k];
        assign amag    = adj_abs[31:0];

        // numerator is amag << 24; its top part must stay below the divisor
        // or the quotient needs more than 32 bits
        always_comb
        begin
            lane_next.neg = adj_neg ^ det_neg;
            lane_next.ovf = ({24'd0, amag[31:8]} >= dmag_next);
            lane_next.rem = {24'd0, amag[31:8]};
            lane_next.num = {amag[7:0], 24'd0};
            lane_next.quo = '0;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                adj_c_reg[k] <= adj[k];
                adj_d_reg[k] <= adj_c_reg[k];
                lane_reg[k]  <= lane_next;
            end
        end
        assign lane_out[k] = lane_reg[k];
    end

    assign ctl_out = ctl_e_reg;
    assign dmag    = dmag_reg;

endmodule

### hw/rtl/m3i_div.sv
// Restoring divider, one quotient bit per stage, nine lanes sharing a divisor
module m3i_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  m3i_pkg::ctl_t       ctl_in,
    input  m3i_pkg::lane_t      lane_in [m3i_pkg::LANES],
    input  logic [47:0]         dmag,
    output m3i_pkg::ctl_t       ctl_out,
    output m3i_pkg::lane_t      lane_out [m3i_pkg::LANES]
);

    localparam int S = m3i_pkg::DIV_STAGES;

    m3i_pkg::ctl_t  ctl_reg  [S];
    m3i_pkg::lane_t lane_reg [S][m3i_pkg::LANES];
    logic [47:0]    dmag_reg [S-1];

    for (genvar s = 0; s < S; s++)
    begin : g_stage
        m3i_pkg::ctl_t  cur_ctl;
        m3i_pkg::lane_t cur [m3i_pkg::LANES];
        logic [47:0]    cur_d;

        if (s == 0)
        begin : g_first
            assign cur_ctl = ctl_in;
            assign cur     = lane_in;
            assign cur_d   = dmag;
        end
        else
        begin : g_rest
            assign cur_ctl = ctl_reg[s-1];
            assign cur     = lane_reg[s-1];
            assign cur_d   = dmag_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[s] <= '0;
            else if (en)
                ctl_reg[s] <= cur_ctl;
        end

        if (s < S - 1)
        begin : g_dpass
            always_ff @(posedge clk)
            begin
                if (en)
                    dmag_reg[s] <= cur_d;
            end
        end

        for (genvar l = 0; l < m3i_pkg::LANES; l++)
        begin : g_lane
            logic [48:0]    trial;
            logic           ge;
            logic [48:0]    diff;
            m3i_pkg::lane_t lane_next;

            assign trial = {cur[l].rem, cur[l].num[31]};
            assign ge    = (trial >= {1'b0, cur_d});
            assign diff  = trial - {1'b0, cur_d};

            always_comb
            begin
                lane_next     = cur[l];
                lane_next.rem = ge ? diff[47:0] : trial[47:0];
                lane_next.num = {cur[l].num[30:0], 1'b0};
                lane_next.quo = {cur[l].quo[30:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    lane_reg[s][l] <= lane_next;
            end
        end
    end

    assign ctl_out  = ctl_reg[S-1];
    assign lane_out = lane_reg[S-1];

endmodule

### hw/rtl/matrix3_inverse.sv
// 3x3 matrix inverse by adjugate: takes one Q8.8 matrix word per cycle and
// returns the nine Q16.16 inverse elements, truncated toward zero. The word
// passes two adjugate stages, three determinant stages, the 32 restoring
// divider stages (one quotient bit each) and the output register. The
// pipeline holds as a whole while the output word is not taken, so
// throughput is one matrix per cycle whenever the sink is ready. A zero
// determinant gives zeros with singular set; a clipped element sets saturated.
`include "matrix3_inverse_assert.svh"

module matrix3_inverse (
    input  logic      clk,
    input  logic      rst_n,
    m3i_in_if.sink    req,
    m3i_out_if.source rsp
);

    logic                adv;
    m3i_pkg::ctl_t       ctl_in;
    m3i_pkg::elem_t      mat [m3i_pkg::LANES];
    m3i_pkg::ctl_t       adj_ctl, det_ctl, div_ctl;
    m3i_pkg::adj_t       adj [m3i_pkg::LANES];
    m3i_pkg::elem_t      row0 [3];
    m3i_pkg::lane_t      det_lane [m3i_pkg::LANES];
    m3i_pkg::lane_t      div_lane [m3i_pkg::LANES];
    logic [47:0]         dmag;

    logic                valid_reg;
    logic                singular_reg;
    logic                saturated_reg;
    logic [31:0]         r_reg  [m3i_pkg::LANES];
    logic [31:0]         r_next [m3i_pkg::LANES];
    logic [m3i_pkg::LANES-1:0] sat_next;
    logic                r_zero;
    logic                sing_word_ok;

    assign adv       = !valid_reg || rsp.ready;
    assign req.ready = adv;

    assign ctl_in.valid    = req.valid;
    assign ctl_in.singular = 1'b0;

    assign mat[0] = req.m00;
    assign mat[1] = req.m01;
    assign mat[2] = req.m02;
    assign mat[3] = req.m10;
    assign mat[4] = req.m11;
    assign mat[5] = req.m12;
    assign mat[6] = req.m20;
    assign mat[7] = req.m21;
    assign mat[8] = req.m22;

    m3i_adj u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (ctl_in),
        .mat     (mat),
        .ctl_out (adj_ctl),
        .adj     (adj),
        .row0    (row0)
    );

    m3i_det u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .ctl_in   (adj_ctl),
        .adj      (adj),
        .row0     (row0),
        .ctl_out  (det_ctl),
        .lane_out (det_lane),
        .dmag     (dmag)
    );

    m3i_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .ctl_in   (det_ctl),
        .lane_in  (det_lane),
        .dmag     (dmag),
        .ctl_out  (div_ctl),
        .lane_out (div_lane)
    );

    // sign and range fix-up on the unsigned quotient
    for (genvar l = 0; l < m3i_pkg::LANES; l++)
    begin : g_fix
        logic [31:0] q;
        logic        neg;
        logic        clip;

        assign q    = div_lane[l].quo;
        assign neg  = div_lane[l].neg;
        assign clip = div_lane[l].ovf || (!neg && q[31]) ||
                      (neg && (q > m3i_pkg::Q_MIN_MAG));

        always_comb
        begin
            sat_next[l] = 1'b0;
            if (div_ctl.singular)
                r_next[l] = '0;
            else if (clip)
            begin
                sat_next[l] = 1'b1;
                r_next[l]   = neg ? m3i_pkg::Q_MIN : m3i_pkg::Q_MAX;
            end
            else
                r_next[l] = neg ? (~q + 32'd1) : q;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                r_reg[l] <= r_next[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= div_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            singular_reg  <= div_ctl.singular;
            saturated_reg <= !div_ctl.singular && (|sat_next);
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.singular  = singular_reg;
    assign rsp.saturated = saturated_reg;
    assign rsp.r00 = r_reg[0];
    assign rsp.r01 = r_reg[1];
    assign rsp.r02 = r_reg[2];
    assign rsp.r10 = r_reg[3];
    assign rsp.r11 = r_reg[4];
    assign rsp.r12 = r_reg[5];
    assign rsp.r20 = r_reg[6];
    assign rsp.r21 = r_reg[7];
    assign rsp.r22 = r_reg[8];

    assign r_zero = (rsp.r00 == '0) && (rsp.r01 == '0) && (rsp.r02 == '0) &&
                    (rsp.r10 == '0) && (rsp.r11 == '0) && (rsp.r12 == '0) &&
                    (rsp.r20 == '0) && (rsp.r21 == '0) && (rsp.r22 == '0);
    assign sing_word_ok = r_zero && !rsp.saturated;

    `M3I_ASSERT_IMP(a_sing_zero, rsp.valid && rsp.singular, sing_word_ok, "singular word not zero")
    `M3I_ASSERT_IMP(a_sat_excl, rsp.valid && rsp.saturated, !rsp.singular, "saturated and singular")
    `M3I_ASSERT_NXT(a_div_hold, !adv && div_ctl.valid, div_ctl.valid, "divider word lost")

endmodule
